>>> hw/rtl/nfrt_pkg.sv
// ----------------------------------------------------------------------------
// nfrt_pkg
// Shared codes of the nearest-first request table: commands, result status
// and configuration register indexes.
// ----------------------------------------------------------------------------
package nfrt_pkg;

	typedef enum logic [0:0] {
		CMD_ADD  = 1'b0,
		CMD_SORT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_APPEND  = 3'd0,
		ST_MOVED   = 3'd1,
		ST_DROPPED = 3'd2,
		ST_ENTRY   = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_ROOT_X = 2'd0,
		REG_ROOT_Y = 2'd1,
		REG_ROOT_Z = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

endpackage

>>> hw/rtl/nfrt_ram.sv
// ----------------------------------------------------------------------------
// nfrt_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module nfrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/nfrt_weight.sv
// ----------------------------------------------------------------------------
// nfrt_weight
// Weighted squared distance dx^2 + dy^2 + (2dz)^2 from the root. Squares are
// registered; the sum is formed in the following cycle.
// ----------------------------------------------------------------------------
module nfrt_weight #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic signed [COORD_BITS-1:0] x,
	input  logic signed [COORD_BITS-1:0] y,
	input  logic signed [COORD_BITS-1:0] z,
	input  logic signed [COORD_BITS-1:0] rx,
	input  logic signed [COORD_BITS-1:0] ry,
	input  logic signed [COORD_BITS-1:0] rz,
	output logic [2*COORD_BITS+2:0]      weight
);

	localparam int C  = COORD_BITS;
	localparam int WB = 2 * C + 3;

	logic signed [C:0]       dx, dy, dz;
	logic signed [C+1:0]     dz2;
	logic signed [2*C+1:0]   sqx_s1, sqy_s1;
	logic signed [2*C+3:0]   sqz_s1;

	assign dx  = (C+1)'(x) - (C+1)'(rx);
	assign dy  = (C+1)'(y) - (C+1)'(ry);
	assign dz  = (C+1)'(z) - (C+1)'(rz);
	assign dz2 = {dz, 1'b0};

	always_ff @(posedge clk) begin
		sqx_s1 <= dx * dx;
		sqy_s1 <= dy * dy;
		sqz_s1 <= dz2 * dz2;
	end

	// all squares are non-negative and the sum fits in WB bits
	assign weight = {1'b0, sqx_s1} + {1'b0, sqy_s1} + sqz_s1[WB-1:0];

endmodule

>>> hw/rtl/nearest_first_request_table.sv
// ----------------------------------------------------------------------------
// nearest_first_request_table
// Ordered table of 3-D request positions with a check flag, sorted on demand
// by weighted distance from a configurable root.
// ----------------------------------------------------------------------------
// Usage:
//  - Write root_x/y/z through cfg_we/cfg_index/cfg_data while the block idles.
//  - Input items on s_*: s_tuser is the command (add or sort), s_tdata holds
//    the position and check flag. s_tready is high only while no command is
//    in progress; one command is worked at a time.
//  - An add scans the held entries for its position, shifts the entries
//    behind a found position down one place, writes the entry (none when
//    a full table drops it) and posts one result item.
//  - A sort computes and stores each weight, runs a stable insertion sort
//    in the table memory, then emits every entry in order with m_tlast on
//    the final one. An empty table gives one item with the empty status.
//  - The table memory has one read and one write port.
//  - Results leave through an output register; when the receiver stalls the
//    sequencer holds at the result it wants to post.
//  - Reset clears the fill count, the roots and the output valid; table
//    contents are not cleared and only entries below the count are read.
// ----------------------------------------------------------------------------
module nearest_first_request_table
	import nfrt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int COORD_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	// input items
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// tdata: pos_x, pos_y, pos_z, check_file (lowest first), zero padded
	input  logic [((3*COORD_BITS+1+7)/8)*8-1:0] s_tdata,
	// tuser: command
	input  logic                  s_tuser,
	// result items
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// tdata: out_x, out_y, out_z, out_check, weight, entry_count (lowest first)
	output logic [((5*COORD_BITS+4+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
	// tuser: status
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int C      = COORD_BITS;
	localparam int WB     = 2 * C + 3;
	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int EW     = 3 * C + 1;
	localparam int MW     = EW + WB;
	localparam int OUT_DW = EW + WB + CW;
	localparam int OUT_W  = ((OUT_DW + 7) / 8) * 8;

	typedef enum logic [4:0] {
		S_IDLE, S_SR_RD, S_SR_CMP, S_SH_RD, S_SH_WR, S_PUT, S_RES,
		S_W_RD, S_W_MUL, S_W_SUM, S_I_KEY, S_I_KLD, S_I_RD, S_I_CMP,
		S_I_PUT, S_EM_RD, S_EM_OUT
	} state_t;

	state_t state_q;

	logic signed [C-1:0] root_x_q, root_y_q, root_z_q;
	logic [CW-1:0]       fill_q, k_q, i_q, j_q;
	logic [AW-1:0]       at_q;
	logic                found_q, old_ck_q;
	logic [EW-1:0]       new_q;
	logic [MW-1:0]       key_q;
	status_t             status_q;

	logic [EW-1:0]       out_entry_q;
	logic [WB-1:0]       out_weight_q;
	logic [CW-1:0]       out_count_q;
	status_t             out_status_q;
	logic                out_last_q, out_valid_q;

	// table memory word: {weight, check, z, y, x}
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [MW-1:0] ram_wdata, ram_rdata;
	logic [WB-1:0] wgt_sum;

	logic          out_free, match, last_scan, res_post;
	logic [CW-1:0] k_next;

	nfrt_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	nfrt_weight #(.COORD_BITS(C)) u_weight (
		.clk   (clk),
		.x     (ram_rdata[C-1:0]),
		.y     (ram_rdata[2*C-1:C]),
		.z     (ram_rdata[3*C-1:2*C]),
		.rx    (root_x_q),
		.ry    (root_y_q),
		.rz    (root_z_q),
		.weight(wgt_sum)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_W'({out_count_q, out_weight_q, out_entry_q});

	assign out_free  = !out_valid_q || m_tready;
	assign match     = (ram_rdata[3*C-1:0] == new_q[3*C-1:0]);
	assign k_next    = k_q + CW'(1);
	assign last_scan = (k_next == fill_q);
	// a result item is loaded into the output register this cycle
	assign res_post  = out_free && (state_q == S_RES || state_q == S_EM_OUT);

	// memory port control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = k_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = k_q[AW-1:0];
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_SR_RD, S_SH_RD, S_W_RD, S_EM_RD: begin
				ram_re = 1'b1;
			end
			S_I_KEY: begin
				ram_re    = 1'b1;
				ram_raddr = i_q[AW-1:0];
			end
			S_I_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(j_q - CW'(1));
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(k_q - CW'(1));
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = found_q ? AW'(fill_q - CW'(1)) : fill_q[AW-1:0];
				ram_wdata = {WB'(0), found_q ? (new_q[EW-1] & old_ck_q) : new_q[EW-1],
					new_q[3*C-1:0]};
			end
			S_W_SUM: begin
				ram_we    = 1'b1;
				ram_wdata = {wgt_sum, ram_rdata[EW-1:0]};
			end
			S_I_CMP: begin
				ram_we    = (ram_rdata[MW-1:EW] > key_q[MW-1:EW]);
				ram_waddr = j_q[AW-1:0];
			end
			S_I_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = key_q;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_x_q <= '0;
			root_y_q <= '0;
			root_z_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROOT_X: root_x_q <= cfg_data;
				REG_ROOT_Y: root_y_q <= cfg_data;
				REG_ROOT_Z: root_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_post) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						new_q   <= s_tdata[EW-1:0];
						k_q     <= '0;
						found_q <= 1'b0;
						if (cmd_t'(s_tuser) == CMD_ADD) begin
							status_q <= ST_APPEND;
							state_q  <= (fill_q == '0) ? S_PUT : S_SR_RD;
						end else if (fill_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_RES;
						end else begin
							state_q <= S_W_RD;
						end
					end
				end
				S_SR_RD: state_q <= S_SR_CMP;
				S_SR_CMP: begin
					// keep the last match, as the scan runs front to back
					if (match) begin
						found_q  <= 1'b1;
						at_q     <= k_q[AW-1:0];
						old_ck_q <= ram_rdata[EW-1];
					end
					if (!last_scan) begin
						k_q     <= k_next;
						state_q <= S_SR_RD;
					end else if (match || found_q) begin
						status_q <= ST_MOVED;
						k_q      <= match ? k_next : CW'(at_q) + CW'(1);
						state_q  <= (match || (CW'(at_q) + CW'(1) == fill_q)) ?
							S_PUT : S_SH_RD;
					end else if (fill_q < CW'(TABLE_DEPTH)) begin
						status_q <= ST_APPEND;
						state_q  <= S_PUT;
					end else begin
						status_q <= ST_DROPPED;
						state_q  <= S_RES;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					k_q     <= k_next;
					state_q <= last_scan ? S_PUT : S_SH_RD;
				end
				S_PUT: begin
					if (!found_q) begin
						fill_q <= fill_q + CW'(1);
					end
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_entry_q  <= '0;
						out_weight_q <= '0;
						out_count_q  <= fill_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_W_RD:  state_q <= S_W_MUL;
				S_W_MUL: state_q <= S_W_SUM;
				S_W_SUM: begin
					i_q <= CW'(1);
					if (last_scan) begin
						k_q     <= '0;
						state_q <= (fill_q == CW'(1)) ? S_EM_RD : S_I_KEY;
					end else begin
						k_q     <= k_next;
						state_q <= S_W_RD;
					end
				end
				S_I_KEY: state_q <= S_I_KLD;
				S_I_KLD: begin
					key_q   <= ram_rdata;
					j_q     <= i_q;
					state_q <= S_I_RD;
				end
				S_I_RD: state_q <= S_I_CMP;
				S_I_CMP: begin
					// move the larger entry up one place and keep walking down
					if (ram_rdata[MW-1:EW] > key_q[MW-1:EW]) begin
						j_q     <= j_q - CW'(1);
						state_q <= (j_q == CW'(1)) ? S_I_PUT : S_I_RD;
					end else begin
						state_q <= S_I_PUT;
					end
				end
				S_I_PUT: begin
					i_q <= i_q + CW'(1);
					if (i_q + CW'(1) == fill_q) begin
						k_q     <= '0;
						state_q <= S_EM_RD;
					end else begin
						state_q <= S_I_KEY;
					end
				end
				S_EM_RD: state_q <= S_EM_OUT;
				S_EM_OUT: begin
					if (out_free) begin
						out_status_q <= ST_ENTRY;
						out_entry_q  <= ram_rdata[EW-1:0];
						out_weight_q <= ram_rdata[MW-1:EW];
						out_count_q  <= fill_q;
						out_last_q   <= last_scan;
						k_q          <= k_next;
						state_q      <= last_scan ? S_IDLE : S_EM_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// fill count never passes the table depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
		else $error("fill count above table depth");

	// writes stay inside the held entries, or one past them on append
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= fill_q))
		else $error("table write beyond fill count");

	// the sequencer never reads and writes one entry in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write of one entry in one cycle");

	// a sorted entry item always reports a non-empty table
	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_ENTRY) |-> (out_count_q != '0))
		else $error("sorted entry with empty count");

	// an accepted command leaves the idle state in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("block idle right after accepting a command");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-first request table. Add and sort
// commands stream in with random gaps and random output stalls. A table
// predictor in the bench works out the status and every emitted entry of
// each command, and the monitor compares every result item field by field.
// ----------------------------------------------------------------------------
import nfrt_pkg::*;

class request_table_board;
	typedef struct {
		status_t     status;
		logic [15:0] x, y, z;
		logic        ck;
		logic [34:0] weight;
		logic [6:0]  count;
		logic        last;
	} result_t;

	logic signed [15:0] root_x, root_y, root_z;
	logic signed [15:0] tx[64], ty[64], tz[64];
	logic               tc[64];
	int                 fill;
	result_t            due[$];
	int                 errors;

	function new();
		root_x = 0; root_y = 0; root_z = 0;
		fill = 0; errors = 0;
	endfunction

	function longint unsigned dist_of(int i);
		longint dx, dy, dz;
		dx = longint'(tx[i]) - longint'(root_x);
		dy = longint'(ty[i]) - longint'(root_y);
		dz = 2 * (longint'(tz[i]) - longint'(root_z));
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// note an accepted command and queue the results it causes
	function void note(cmd_t cmd, logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz, logic ck);
		result_t r;
		int at, j;
		logic old, kc;
		logic signed [15:0] kx, ky, kz;
		longint unsigned kw;
		r = '{ST_APPEND, 0, 0, 0, 0, 0, 0, 1};
		if (cmd == CMD_ADD) begin
			at = -1;
			for (int i = 0; i < fill; i++)
				if (tx[i] == px && ty[i] == py && tz[i] == pz) at = i;
			if (at >= 0) begin
				old = tc[at];
				for (j = at; j + 1 < fill; j++) begin
					tx[j] = tx[j+1]; ty[j] = ty[j+1]; tz[j] = tz[j+1]; tc[j] = tc[j+1];
				end
				tx[fill-1] = px; ty[fill-1] = py; tz[fill-1] = pz; tc[fill-1] = ck & old;
				r.status = ST_MOVED;
			end else if (fill < 64) begin
				tx[fill] = px; ty[fill] = py; tz[fill] = pz; tc[fill] = ck;
				fill++;
				r.status = ST_APPEND;
			end else
				r.status = ST_DROPPED;
			r.count = 7'(fill);
			due = {due, r};
			return;
		end
		if (fill == 0) begin
			r.status = ST_EMPTY;
			due = {due, r};
			return;
		end
		// stable insertion sort: equal weights keep their order
		for (int i = 1; i < fill; i++) begin
			kx = tx[i]; ky = ty[i]; kz = tz[i]; kc = tc[i];
			kw = dist_of(i);
			j = i;
			while (j > 0 && dist_of(j - 1) > kw) begin
				tx[j] = tx[j-1]; ty[j] = ty[j-1]; tz[j] = tz[j-1]; tc[j] = tc[j-1];
				j--;
			end
			tx[j] = kx; ty[j] = ky; tz[j] = kz; tc[j] = kc;
		end
		for (int i = 0; i < fill; i++) begin
			r.status = ST_ENTRY;
			r.x = tx[i]; r.y = ty[i]; r.z = tz[i]; r.ck = tc[i];
			r.weight = 35'(dist_of(i));
			r.count = 7'(fill);
			r.last = (i + 1 == fill);
			due = {due, r};
		end
	endfunction

	// compare one result item with the oldest expectation
	function void check(logic [2:0] st, logic [95:0] d, logic lst);
		result_t e;
		result_t a;
		a.status = status_t'(st);
		a.x = d[15:0]; a.y = d[31:16]; a.z = d[47:32]; a.ck = d[48];
		a.weight = d[83:49]; a.count = d[90:84]; a.last = lst;
		if (due.size() == 0) begin
			$display("%0t: unexpected result status=%0d data=%h", $time, st, d);
			errors++;
			return;
		end
		e = due.pop_front();
		if (a.status !== e.status || a.x !== e.x || a.y !== e.y || a.z !== e.z ||
				a.ck !== e.ck || a.weight !== e.weight || a.count !== e.count ||
				a.last !== e.last || d[95:91] !== 0) begin
			$display("%0t: mismatch expected st=%0d x=%h y=%h z=%h ck=%b w=%0d n=%0d last=%b",
				$time, e.status, e.x, e.y, e.z, e.ck, e.weight, e.count, e.last);
			$display("%0t:          actual   st=%0d x=%h y=%h z=%h ck=%b w=%0d n=%0d last=%b",
				$time, a.status, a.x, a.y, a.z, a.ck, a.weight, a.count, a.last);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 20000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_NONE;
	logic [15:0] cfg_data = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [55:0] s_tdata = 0;   // pos_x, pos_y, pos_z, check_file, pad
	logic        s_tuser = CMD_ADD; // command
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [95:0] m_tdata;       // out_x, out_y, out_z, out_check, weight, entry_count
	logic [2:0]  m_tuser;       // status
	logic        m_tlast;

	request_table_board board;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int cycles = 0;
	logic [47:0] pool[80];

	nearest_first_request_table uut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// guard against a hung block
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor: sample before this edge's updates land
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) board.check(m_tuser, m_tdata, m_tlast);

	// offer one command, idling first at random, and hold until accepted
	task automatic send_cmd(cmd_t cmd, logic [15:0] px, logic [15:0] py,
			logic [15:0] pz, logic ck);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'b0, ck, pz, py, px};
		do @(posedge clk); while (!s_tready);
		board.note(cmd, px, py, pz, ck);
	endtask

	// drop valid and wait until every expected item is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_root(reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_index <= REG_NONE;
		case (idx)
			REG_ROOT_X: board.root_x = val;
			REG_ROOT_Y: board.root_y = val;
			REG_ROOT_Z: board.root_z = val;
			default: ;
		endcase
	endtask

	task automatic set_roots(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
		write_root(REG_ROOT_X, rx);
		write_root(REG_ROOT_Y, ry);
		write_root(REG_ROOT_Z, rz);
	endtask

	// mostly pool positions so refreshes and a full table occur; some noise
	task automatic random_cmd();
		logic [47:0] p;
		int pick;
		pick = $urandom_range(99);
		if (pick < 7)
			send_cmd(CMD_SORT, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
		else begin
			p = (pick < 85) ? pool[$urandom_range(79)] : 48'({$urandom, $urandom});
			send_cmd(CMD_ADD, p[15:0], p[31:16], p[47:32], 1'($urandom_range(1)));
		end
	endtask

	initial begin
		board = new();
		for (int i = 0; i < 80; i++) pool[i] = 48'({$urandom, $urandom});
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty sort, coordinate extremes, refresh with flag AND,
		// equal weights, sort from the reset root
		send_cmd(CMD_SORT, 0, 0, 0, 0);
		send_cmd(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 1);
		send_cmd(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 1);
		send_cmd(CMD_ADD, 0, 0, 0, 0);
		send_cmd(CMD_ADD, 16'h7fff, 16'h8000, 16'h0000, 1);
		send_cmd(CMD_ADD, 16'h0001, 0, 0, 1);
		send_cmd(CMD_ADD, 16'hffff, 0, 0, 0);
		send_cmd(CMD_ADD, 0, 0, 16'h0001, 1);
		send_cmd(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 0);
		send_cmd(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 1);
		send_cmd(CMD_ADD, 16'h0001, 0, 0, 1);
		send_cmd(CMD_SORT, 0, 0, 0, 0);
		drain();
		set_roots(16'h8000, 16'h8000, 16'h8000);
		send_cmd(CMD_SORT, 0, 0, 0, 0);
		drain();
		set_roots(16'h7fff, 16'h7fff, 16'h7fff);
		send_cmd(CMD_SORT, 0, 0, 0, 0);
		drain();

		// random phases, each with its own idling and root
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  set_roots(0, 0, 0); end
				1: begin idle_pct = 76; stall_pct = 0;  set_roots(16'h8000, 16'h7fff, 16'h8000); end
				2: begin
					idle_pct = 0; stall_pct = 76;
					set_roots(16'($urandom), 16'($urandom), 16'($urandom));
				end
				default: begin idle_pct = 24; stall_pct = 24; set_roots(16'h7fff, 16'h8000, 0); end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (ph == 2) hold_req = 400;
			for (int n = 0; n < 85; n++) begin
				random_cmd();
				// stretches with no idling at all
				if (n == 40) begin idle_pct = 0; stall_pct = 0; end
			end
			send_cmd(CMD_SORT, 0, 0, 0, 0);
			drain();
		end

		if (board.errors == 0 && board.due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/nfrt_pkg.sv
hw/rtl/nfrt_ram.sv
hw/rtl/nfrt_weight.sv
hw/rtl/nearest_first_request_table.sv
dv/tb.sv
